FILE: rtl/swrm_pkg.sv
package swrm_pkg;

  // field widths
  localparam int unsigned TS_W       = 48;
  localparam int unsigned CNT_W      = 48;
  localparam int unsigned RATE_W     = 48;
  localparam int unsigned MEAN_W     = 56;
  localparam int unsigned FILL_OUT_W = 11;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned WINDOW_W   = 10;
  localparam int unsigned SAMPLES_W  = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS  = 2'd1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 10'd10;

  // shared divider: count*1000 scaled by 256 needs 66 bits, time span 48
  localparam int unsigned DIV_NUM_W = 66;
  localparam int unsigned DIV_DEN_W = 48;

  localparam int unsigned DEPTH_DEFAULT = 64;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/swrm_ram.sv
module swrm_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/swrm_div.sv
module swrm_div #(
  parameter int unsigned NUM_W = swrm_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = swrm_pkg::DIV_DEN_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output swrm_pkg::div_stat_t stat_o,
  output logic [NUM_W-1:0]    quo_o
);

  import swrm_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(NUM_W + 1);

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [NUM_W-1:0]    quo_q, quo_d;   // numerator shifts out, quotient shifts in
  logic [DEN_W-1:0]    rem_q, rem_d;
  logic [DEN_W-1:0]    den_q, den_d;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // one restoring step: one quotient bit per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = CNT_BITS'(NUM_W);
      busy_d = 1'b1;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

FILE: rtl/sliding_window_rate_meter.sv
// sliding window rate meter
//
// input channel: one word per item (cmd_i, timestamp_ms_i, counter_value_i),
// taken at a rising edge with in_valid_i high and in_stall_o low. cmd_i high
// clears the history and restarts it at that timestamp with count zero.
// output channel: one result word per input word (window_rate_o,
// average_rate_q8_o, stored_o, filled_entries_o), held in an output register
// and taken when out_valid_o is high and out_stall_i is low.
// configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 sample interval,
// 1 window length) and cfg_data_i; cfg_ready_o is always high.
// items are worked one at a time through a shared radix-2 divider, one
// quotient bit per cycle. a word that stores nothing costs one divide
// (window rate), and so does a first store; a store that updates the running
// mean adds two divides; a clear or a window that needs no divide skips the divider.
// the next word is taken as soon as the result is in the output register,
// even while the receiver stalls; a stalled result waits in that register
// and holds the block only if the following result is ready before it goes.
// reset: sample interval 1000 ms, window 10 entries, empty history with the
// start entry at time zero and count zero, output register empty.
module sliding_window_rate_meter #(
  parameter int unsigned DEPTH = swrm_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [swrm_pkg::TS_W-1:0]           timestamp_ms_i,
  input  logic [swrm_pkg::CNT_W-1:0]          counter_value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [swrm_pkg::RATE_W-1:0]         window_rate_o,
  output logic [swrm_pkg::MEAN_W-1:0]         average_rate_q8_o,
  output logic                                stored_o,
  output logic [swrm_pkg::FILL_OUT_W-1:0]     filled_entries_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [swrm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import swrm_pkg::*;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W  = TS_W + CNT_W;
  localparam int unsigned PROD_W = CNT_W + 5;    // count * 24
  localparam int unsigned SCL_W  = CNT_W + 10;   // count * 1000

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CHECK = 14'b00000000000010,
    S_MUL1  = 14'b00000000000100,
    S_MUL2  = 14'b00000000001000,
    S_DINST = 14'b00000000010000,
    S_MEANA = 14'b00000000100000,
    S_MEANB = 14'b00000001000000,
    S_DMEAN = 14'b00000010000000,
    S_STORE = 14'b00000100000000,
    S_WIN   = 14'b00001000000000,
    S_RA    = 14'b00010000000000,
    S_RD    = 14'b00100000000000,
    S_DWIN  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [WINDOW_W-1:0]   window_q, window_d;

  // accepted word
  logic             cmd_q;
  logic [TS_W-1:0]  ts_q;
  logic [CNT_W-1:0] cv_q;

  // newest ring entry kept in flops, so the ring is read only for the window start
  logic [TS_W-1:0]      head_time_q, head_time_d;
  logic [CNT_W-1:0]     head_count_q, head_count_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [FILL_W-1:0]    filled_q, filled_d;
  logic [MEAN_W-1:0]    mean_q, mean_d;
  logic [SAMPLES_W-1:0] samples_q, samples_d;
  logic                 ring0_wr_q, ring0_wr_d;  // entry zero written since reset

  // datapath scratch
  logic [CNT_W-1:0]  dv_q, dv_d;
  logic [TS_W-1:0]   dt_q, dt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              is_win_q, is_win_d;
  logic [MEAN_W-1:0] inst_q, inst_d;
  logic              ge_q, ge_d;
  logic [MEAN_W-1:0] diff_q, diff_d;
  logic [IDX_W-1:0]  rd_addr_q, rd_addr_d;
  logic              rd_zero_q, rd_zero_d;
  logic              stored_q, stored_d;
  logic [RATE_W-1:0] win_rate_q, win_rate_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [RATE_W-1:0]     out_rate_q;
  logic [MEAN_W-1:0]     out_mean_q;
  logic                  out_stored_q;
  logic [FILL_OUT_W-1:0] out_filled_q;
  logic                  out_load;

  // ring and divider hookup
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_quo;

  // combinational helpers
  logic                  in_accept;
  logic                  store_due;
  logic [IDX_W-1:0]      head_nx;
  logic [FILL_OUT_W-1:0] win_len;
  logic [IDX_W-1:0]      win_w;
  logic [IDX_W-1:0]      start_idx;
  logic [SCL_W-1:0]      scaled;
  logic [TS_W-1:0]       t0;
  logic [CNT_W-1:0]      c0;
  logic [SAMPLES_W:0]    n_plus1;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  // store when strictly later than newest entry plus the interval
  assign store_due = {1'b0, ts_q} >
                     ({1'b0, head_time_q} + {{(TS_W + 1 - INTERVAL_W){1'b0}}, interval_q});

  assign head_nx = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

  // window length clamped to filled entries and to depth - 1
  always_comb begin
    win_len = {{(FILL_OUT_W - WINDOW_W){1'b0}}, window_q};
    if (win_len > FILL_OUT_W'(filled_q)) begin
      win_len = FILL_OUT_W'(filled_q);
    end
    if (win_len > FILL_OUT_W'(DEPTH - 1)) begin
      win_len = FILL_OUT_W'(DEPTH - 1);
    end
  end
  assign win_w = win_len[IDX_W-1:0];

  always_comb begin
    if (head_q >= win_w) begin
      start_idx = head_q - win_w;
    end else begin
      start_idx = IDX_W'(({1'b0, head_q} + (IDX_W + 1)'(DEPTH)) - {1'b0, win_w});
    end
  end

  // x * 1000 = x * 1024 - x * 24
  assign scaled = {dv_q, 10'b0} - {5'b0, prod_q};

  // an entry zero never written since reset reads as the start point
  assign t0 = rd_zero_q ? '0 : ram_rdata[ENT_W-1:CNT_W];
  assign c0 = rd_zero_q ? '0 : ram_rdata[CNT_W-1:0];

  assign n_plus1 = {1'b0, samples_q} + (SAMPLES_W + 1)'(1);

  // configuration writes
  always_comb begin
    interval_d = interval_q;
    window_d   = window_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SAMPLE_INTERVAL: interval_d = cfg_data_i[INTERVAL_W-1:0];
        REG_WINDOW_SECONDS:  window_d   = cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_time_d  = head_time_q;
    head_count_d = head_count_q;
    head_d       = head_q;
    filled_d     = filled_q;
    mean_d       = mean_q;
    samples_d    = samples_q;
    ring0_wr_d   = ring0_wr_q;
    dv_d         = dv_q;
    dt_d         = dt_q;
    prod_d       = prod_q;
    is_win_d     = is_win_q;
    inst_d       = inst_q;
    ge_d         = ge_q;
    diff_d       = diff_q;
    rd_addr_d    = rd_addr_q;
    rd_zero_d    = rd_zero_q;
    stored_d     = stored_q;
    win_rate_d   = win_rate_q;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = head_nx;
    ram_wdata    = {ts_q, cv_q};
    div_start    = 1'b0;
    div_num      = is_win_q ? {8'b0, scaled} : {scaled, 8'b0};
    div_den      = dt_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        stored_d = 1'b0;
        is_win_d = 1'b0;
        dv_d     = (cv_q >= head_count_q) ? cv_q - head_count_q : '0;
        dt_d     = ts_q - head_time_q;
        if (cmd_q) begin
          // clear: history restarts at this time with count zero
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = {ts_q, {CNT_W{1'b0}}};
          ring0_wr_d   = 1'b1;
          head_time_d  = ts_q;
          head_count_d = '0;
          head_d       = '0;
          filled_d     = '0;
          mean_d       = '0;
          samples_d    = '0;
          state_d      = S_WIN;
        end else if (!store_due) begin
          state_d = S_WIN;
        end else if (filled_q != '0) begin
          state_d = S_MUL1;
        end else begin
          state_d = S_STORE;
        end
      end

      S_MUL1: begin
        prod_d  = {1'b0, dv_q, 4'b0} + {2'b0, dv_q, 3'b0};
        state_d = S_MUL2;
      end

      S_MUL2: begin
        div_start = 1'b1;
        state_d   = is_win_q ? S_DWIN : S_DINST;
      end

      S_DINST: begin
        if (div_stat.done) begin
          inst_d  = (|div_quo[DIV_NUM_W-1:MEAN_W]) ? '1 : div_quo[MEAN_W-1:0];
          state_d = S_MEANA;
        end
      end

      S_MEANA: begin
        ge_d    = inst_q >= mean_q;
        diff_d  = (inst_q >= mean_q) ? inst_q - mean_q : mean_q - inst_q;
        state_d = S_MEANB;
      end

      S_MEANB: begin
        // rounding term n is added when the mean moves down
        div_start = 1'b1;
        div_num   = ge_q ? DIV_NUM_W'(diff_q)
                         : DIV_NUM_W'({1'b0, diff_q} + (MEAN_W + 1)'(samples_q));
        div_den   = DIV_DEN_W'(n_plus1);
        state_d   = S_DMEAN;
      end

      S_DMEAN: begin
        if (div_stat.done) begin
          mean_d = ge_q ? mean_q + div_quo[MEAN_W-1:0] : mean_q - div_quo[MEAN_W-1:0];
          if (samples_q != '1) begin
            samples_d = samples_q + SAMPLES_W'(1);
          end
          state_d = S_STORE;
        end
      end

      S_STORE: begin
        ram_we       = 1'b1;
        ram_waddr    = head_nx;
        ram_wdata    = {ts_q, cv_q};
        if (head_nx == '0) begin
          ring0_wr_d = 1'b1;
        end
        head_d       = head_nx;
        head_time_d  = ts_q;
        head_count_d = cv_q;
        if (filled_q < FILL_W'(DEPTH)) begin
          filled_d = filled_q + FILL_W'(1);
        end
        stored_d     = 1'b1;
        state_d      = S_WIN;
      end

      S_WIN: begin
        is_win_d  = 1'b1;
        rd_addr_d = start_idx;
        rd_zero_d = (start_idx == '0) && !ring0_wr_q;
        if (win_w == '0) begin
          win_rate_d = '0;
          state_d    = S_FIN;
        end else begin
          state_d = S_RA;
        end
      end

      S_RA: begin
        state_d = S_RD;
      end

      S_RD: begin
        dv_d = head_count_q - c0;
        dt_d = head_time_q - t0;
        if ((head_time_q <= t0) || (head_count_q < c0)) begin
          win_rate_d = '0;
          state_d    = S_FIN;
        end else begin
          state_d = S_MUL1;
        end
      end

      S_DWIN: begin
        if (div_stat.done) begin
          win_rate_d = (|div_quo[DIV_NUM_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
          state_d    = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      interval_q   <= INTERVAL_RESET;
      window_q     <= WINDOW_RESET;
      head_time_q  <= '0;
      head_count_q <= '0;
      head_q       <= '0;
      filled_q     <= '0;
      mean_q       <= '0;
      samples_q    <= '0;
      ring0_wr_q   <= 1'b0;
      is_win_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      interval_q   <= interval_d;
      window_q     <= window_d;
      head_time_q  <= head_time_d;
      head_count_q <= head_count_d;
      head_q       <= head_d;
      filled_q     <= filled_d;
      mean_q       <= mean_d;
      samples_q    <= samples_d;
      ring0_wr_q   <= ring0_wr_d;
      is_win_q     <= is_win_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      ts_q  <= timestamp_ms_i;
      cv_q  <= counter_value_i;
    end
    dv_q       <= dv_d;
    dt_q       <= dt_d;
    prod_q     <= prod_d;
    inst_q     <= inst_d;
    ge_q       <= ge_d;
    diff_q     <= diff_d;
    rd_addr_q  <= rd_addr_d;
    rd_zero_q  <= rd_zero_d;
    stored_q   <= stored_d;
    win_rate_q <= win_rate_d;
    if (out_load) begin
      out_rate_q   <= win_rate_q;
      out_mean_q   <= mean_q;
      out_stored_q <= stored_q;
      out_filled_q <= FILL_OUT_W'(filled_q);
    end
  end

  swrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  swrm_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  assign out_valid_o       = out_valid_q;
  assign window_rate_o     = out_rate_q;
  assign average_rate_q8_o = out_mean_q;
  assign stored_o          = out_stored_q;
  assign filled_entries_o  = out_filled_q;

  // a taken word closes the input until its result is in the output register
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken twice without a result");

  // divider is only started when free
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // no division left running once the item is done
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  // a stored sample implies a non-empty history
  a_stored_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stored_o) |-> (filled_entries_o != '0))
    else $error("stored word reported with empty history");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import swrm_pkg::*;

  localparam int unsigned RING_DEPTH      = DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned LONG_HOLD       = 700;
  localparam int unsigned CALM_PERIOD     = 1500;
  localparam int unsigned PHASES          = 6;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // indexes past the register list, the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  localparam logic [63:0]         MS_PER_S = 64'd1000;
  localparam logic [TS_W-1:0]     TS_MAX   = '1;
  localparam logic [RATE_W-1:0]   RATE_MAX = '1;
  localparam logic [MEAN_W-1:0]   MEAN_MAX = '1;

  typedef struct packed {
    logic [RATE_W-1:0]     window_rate;
    logic [MEAN_W-1:0]     average_rate_q8;
    logic                  stored;
    logic [FILL_OUT_W-1:0] filled_entries;
  } reading_t;

  // own model of the meter: history ring, running mean, registers, and the
  // readings still owed by the block in the order the words went in
  class rate_meter_scoreboard;
    logic [TS_W-1:0]       ring_time  [RING_DEPTH];
    logic [CNT_W-1:0]      ring_count [RING_DEPTH];
    int unsigned           head;
    int unsigned           fill;
    logic [MEAN_W-1:0]     mean_q8;
    logic [SAMPLES_W-1:0]  rate_count;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [WINDOW_W-1:0]   window_len;
    reading_t              expected_readings [$];
    int unsigned           faults;

    function new();
      foreach (ring_time[i]) begin
        ring_time[i]  = '0;
        ring_count[i] = '0;
      end
      head        = 0;
      fill        = 0;
      mean_q8     = '0;
      rate_count  = '0;
      interval_ms = INTERVAL_RESET;
      window_len  = WINDOW_RESET;
      faults      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SAMPLE_INTERVAL: begin
          interval_ms = data[INTERVAL_W-1:0];
        end
        REG_WINDOW_SECONDS: begin
          window_len = data[WINDOW_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // q48.8 rate since the newest entry, pinned at full scale on overflow
    function logic [MEAN_W-1:0] instant_rate_q8(logic [63:0] dv, logic [63:0] dt);
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      num = dv * MS_PER_S;
      q   = num / dt;
      r   = num % dt;
      if (q > 64'(RATE_MAX)) return MEAN_MAX;
      q = (q << 8) | ((r << 8) / dt);
      return q[MEAN_W-1:0];
    endfunction

    // exact floor of (n*mean + x)/(n+1)
    function void fold_into_mean(logic [MEAN_W-1:0] x);
      logic [63:0] n;
      logic [63:0] avg;
      n   = 64'(rate_count);
      avg = 64'(mean_q8);
      if (64'(x) >= avg) avg = avg + (64'(x) - avg) / (n + 64'd1);
      else avg = avg - ((avg - 64'(x)) + n) / (n + 64'd1);
      mean_q8 = avg[MEAN_W-1:0];
      if (rate_count != '1) rate_count++;
    endfunction

    function logic [RATE_W-1:0] rate_over_window();
      int unsigned span;
      int unsigned first;
      logic [63:0] dt;
      logic [63:0] dc;
      logic [63:0] q;
      span = window_len;
      if (span > fill) span = fill;
      if (span > RING_DEPTH - 1) span = RING_DEPTH - 1;
      first = (head + RING_DEPTH - span) % RING_DEPTH;
      if (ring_time[head] <= ring_time[first] || ring_count[head] < ring_count[first])
        return '0;
      dt = 64'(ring_time[head] - ring_time[first]);
      dc = 64'(ring_count[head] - ring_count[first]);
      q  = (dc * MS_PER_S) / dt;
      return (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    function void note_word(logic c, logic [TS_W-1:0] ts, logic [CNT_W-1:0] cnt);
      reading_t         r;
      int unsigned      h;
      logic [CNT_W-1:0] dv;
      r.stored = 1'b0;
      if (c == CMD_CLEAR) begin
        ring_time[0]  = ts;
        ring_count[0] = '0;
        head          = 0;
        fill          = 0;
        mean_q8       = '0;
        rate_count    = '0;
      end else begin
        h = head;
        if (64'(ts) > 64'(ring_time[h]) + 64'(interval_ms)) begin
          // first store after a clear has no previous point to rate against
          if (fill > 0) begin
            dv = (cnt >= ring_count[h]) ? cnt - ring_count[h] : '0;
            fold_into_mean(instant_rate_q8(64'(dv), 64'(ts - ring_time[h])));
          end
          h             = (h + 1) % RING_DEPTH;
          head          = h;
          ring_time[h]  = ts;
          ring_count[h] = cnt;
          if (fill < RING_DEPTH) fill++;
          r.stored = 1'b1;
        end
      end
      r.window_rate     = rate_over_window();
      r.average_rate_q8 = mean_q8;
      r.filled_entries  = FILL_OUT_W'(fill);
      expected_readings.push_back(r);
    endfunction

    function void check_result(logic [RATE_W-1:0] rate, logic [MEAN_W-1:0] mean,
                               logic stored, logic [FILL_OUT_W-1:0] filled);
      reading_t want;
      if (expected_readings.size() == 0) begin
        faults++;
        $display("%0t: result word with nothing outstanding, rate %0d mean %0d stored %0d fill %0d",
                 $time, rate, mean, stored, filled);
        return;
      end
      want = expected_readings.pop_front();
      if (rate !== want.window_rate) begin
        faults++;
        $display("%0t: window_rate expected %0d actual %0d", $time, want.window_rate, rate);
      end
      if (mean !== want.average_rate_q8) begin
        faults++;
        $display("%0t: average_rate_q8 expected %0d actual %0d",
                 $time, want.average_rate_q8, mean);
      end
      if (stored !== want.stored) begin
        faults++;
        $display("%0t: stored expected %0d actual %0d", $time, want.stored, stored);
      end
      if (filled !== want.filled_entries) begin
        faults++;
        $display("%0t: filled_entries expected %0d actual %0d",
                 $time, want.filled_entries, filled);
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i           = CMD_SAMPLE;
  logic [TS_W-1:0]       timestamp_ms_i  = '0;
  logic [CNT_W-1:0]      counter_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [RATE_W-1:0]     window_rate_o;
  logic [MEAN_W-1:0]     average_rate_q8_o;
  logic                  stored_o;
  logic [FILL_OUT_W-1:0] filled_entries_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  rate_meter_scoreboard board;
  int unsigned          cycles        = 0;
  int unsigned          results_taken = 0;
  logic                 calm;

  // stimulus generator state: time and counter last sent, interval in force
  logic [TS_W-1:0]  now_ms       = '0;
  logic [CNT_W-1:0] last_cnt     = '0;
  int unsigned      gen_interval = 0;

  sliding_window_rate_meter #(
    .DEPTH(RING_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .timestamp_ms_i   (timestamp_ms_i),
    .counter_value_i  (counter_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_rate_o    (window_rate_o),
    .average_rate_q8_o(average_rate_q8_o),
    .stored_o         (stored_o),
    .filled_entries_o (filled_entries_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // one stretch in four runs with no random idling on either side
  assign calm = ((cycles / CALM_PERIOD) % 4) == 3;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time, board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // every result word taken is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(window_rate_o, average_rate_q8_o, stored_o, filled_entries_o);
      results_taken <= results_taken + 1;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [TS_W-1:0] random48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TS_W-1:0];
  endfunction

  // receiver pacing; twice in the run it holds off long enough for the
  // block to fill and stall its input while the sender keeps offering
  initial begin : result_pacing
    int unsigned span;
    int unsigned hold_at;
    hold_at = 120;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (results_taken >= hold_at) begin
        hold_at     = hold_at + 210;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 29) == 0) begin
        span = pick_gap();
        if (span == 0) span = 1;
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // offer one word and return at the edge where it is taken; valid stays
  // high so that a back-to-back word follows without a bubble
  task automatic send_word(input logic c, input logic [TS_W-1:0] ts,
                           input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    timestamp_ms_i  <= ts;
    counter_value_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(c, ts, cnt);
  endtask

  // registers change only with nothing in flight; stray indexes and junk
  // above the window width go along to check they are dropped
  task automatic program_meter(input logic [INTERVAL_W-1:0] interval,
                               input logic [WINDOW_W-1:0] span);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    idx = '{REG_UNUSED_A, REG_SAMPLE_INTERVAL, REG_UNUSED_B, REG_WINDOW_SECONDS};
    val = '{16'($urandom), interval, 16'($urandom), {6'($urandom), span}};
    gen_interval = interval;
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      board.set_register(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed traffic: rising time and counters, steps around the
  // interval; now and then a clear, a clock going back or a junk counter
  task automatic draw_word(output logic c, output logic [TS_W-1:0] ts,
                           output logic [CNT_W-1:0] cnt);
    int unsigned roll;
    int unsigned flavour;
    logic [63:0] step;
    roll    = $urandom_range(0, 199);
    flavour = $urandom_range(0, 29);
    c       = CMD_SAMPLE;
    ts      = now_ms;
    cnt     = random48();
    if (roll < 2) begin
      c        = CMD_CLEAR;
      ts       = (roll == 0) ? random48() : TS_W'($urandom);
      now_ms   = ts;
      last_cnt = '0;
    end else if (roll < 8) begin
      step = $urandom_range(1, 5000);
      ts   = (64'(now_ms) > step) ? now_ms - step[TS_W-1:0] : '0;
    end else begin
      if (roll < 40) step = $urandom_range(0, gen_interval);
      else if (roll < 70) step = 64'(gen_interval) + 64'd1;
      else step = 64'(gen_interval) + 64'd1 + $urandom_range(0, 3 * gen_interval + 64);
      if (64'(now_ms) + step > 64'(TS_MAX)) begin
        // time would run off the top, start over low down
        c        = CMD_CLEAR;
        ts       = TS_W'($urandom_range(0, 100000));
        now_ms   = ts;
        last_cnt = '0;
      end else begin
        now_ms = now_ms + step[TS_W-1:0];
        ts     = now_ms;
        if (flavour == 0) cnt = last_cnt - CNT_W'($urandom_range(1, 100000));
        else if (flavour == 2) cnt = last_cnt + CNT_W'({8'($urandom), 32'($urandom)});
        else if (flavour != 1) cnt = last_cnt + CNT_W'($urandom_range(0, 2000000));
        last_cnt = cnt;
      end
    end
  endtask

  initial begin : stimulus
    logic                  c;
    logic [TS_W-1:0]       ts;
    logic [CNT_W-1:0]      cnt;
    logic [INTERVAL_W-1:0] phase_interval [PHASES];
    logic [WINDOW_W-1:0]   phase_window   [PHASES];
    int unsigned           phase_items    [PHASES];
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: 1000 ms interval, window of 10
    send_word(CMD_SAMPLE, 48'd0, 48'd0);          // nothing newer than the start entry
    send_word(CMD_SAMPLE, 48'd1000, 48'd5);       // exactly one interval on, not stored
    send_word(CMD_SAMPLE, 48'd1001, 48'd1000);    // first store, no rate yet
    send_word(CMD_SAMPLE, 48'd2500, 48'd3000);
    send_word(CMD_SAMPLE, 48'd3000, 48'd500);     // inside the interval
    send_word(CMD_SAMPLE, 48'd4000, 48'd100);     // counter fell
    send_word(CMD_SAMPLE, 48'd100, 48'd7);        // clock went back
    send_word(CMD_CLEAR, TS_MAX - 48'd1999, TS_MAX);
    send_word(CMD_SAMPLE, TS_MAX, TS_MAX);
    send_word(CMD_CLEAR, 48'd0, random48());

    // zero interval, shortest window: strictly later time stores
    program_meter(16'd0, 10'd1);
    send_word(CMD_SAMPLE, 48'd0, 48'd0);
    send_word(CMD_SAMPLE, 48'd1, 48'd0);
    send_word(CMD_SAMPLE, 48'd2, TS_MAX);         // both rates pinned at full scale
    send_word(CMD_SAMPLE, 48'd3, 48'd5);          // falling counter drags the mean down
    send_word(CMD_SAMPLE, 48'd3, 48'd9);          // same time, not stored

    // longest interval, window far beyond the history
    program_meter(16'hFFFF, 10'h3FF);
    send_word(CMD_CLEAR, 48'd5, 48'd0);
    send_word(CMD_SAMPLE, 48'd65540, 48'd1);
    send_word(CMD_SAMPLE, 48'd65541, 48'h8000_0000_0000);
    send_word(CMD_SAMPLE, 48'd131082, 48'h8000_0000_1000);
    send_word(CMD_SAMPLE, 48'd131083, TS_MAX);
    now_ms   = 48'd131083;
    last_cnt = 48'h8000_0000_1000;

    // random phases, the long zero-interval one wraps the ring
    phase_interval = '{16'd1000, 16'd0, 16'd3, 16'hFFFF, 16'($urandom),
                       16'($urandom_range(0, 40))};
    phase_window   = '{10'd10, 10'h3FF, 10'd63, 10'd5, 10'($urandom), 10'($urandom)};
    phase_items    = '{60, 130, 70, 60, 70, 60};
    for (int p = 0; p < PHASES; p++) begin
      program_meter(phase_interval[p], phase_window[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        draw_word(c, ts, cnt);
        send_word(c, ts, cnt);
      end
    end

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/swrm_pkg.sv
rtl/swrm_ram.sv
rtl/swrm_div.sv
rtl/sliding_window_rate_meter.sv
verif/testbench.sv
